/* rtl/piecewise_linear_keyframe_animator_macros.svh */
// ---------------------------------------------------------------------------
// piecewise linear keyframe animator assertion macros
// shared concurrent check forms, disabled while the active-low reset is low
// ---------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_KEYFRAME_ANIMATOR_MACROS_SVH
`define PIECEWISE_LINEAR_KEYFRAME_ANIMATOR_MACROS_SVH

// same-cycle implication
`define PLKA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plka check failed");

// next-cycle implication
`define PLKA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plka check failed");

`endif

/* rtl/plka_pkg.sv */
// ---------------------------------------------------------------------------
// plka_pkg
// types and fixed constants of the keyframe animator
// ---------------------------------------------------------------------------
package plka_pkg;

  localparam int CFG_AW    = 3;
  localparam int CNT_W     = 5;
  localparam int DUR_W     = 24;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 29;
  localparam int PER_W     = 16;
  localparam int SUM_W     = 30;
  localparam int DVD_W     = 56;
  localparam int DVS_W     = 32;
  localparam int STEP_W    = 6;
  localparam int MOD_STEPS = 30;
  localparam int DIV_STEPS = 32;

  localparam logic [1:0] OP_DUR   = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  localparam logic REG_SEGS  = 1'b0;
  localparam logic REG_COMPS = 1'b1;

  typedef struct packed {
    logic [1:0]        operation;
    logic [3:0]        segment_index;
    logic [3:0]        component_index;
    logic [23:0]       duration_ms;
    logic signed [31:0] endpoint_value;
    logic [15:0]       period_ms;
  } plka_in_t;

  typedef struct packed {
    logic [3:0]         out_component;
    logic signed [31:0] out_value;
    logic               last;
  } plka_out_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DVD_W-1:0]  dvd;
    logic [DVS_W-1:0]  rem_init;
    logic [DVS_W-1:0]  dvs;
  } plka_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVS_W-1:0] quo;
    logic [DVS_W-1:0] rem;
  } plka_div_rsp_t;

endpackage

/* rtl/plka_ram.sv */
// ---------------------------------------------------------------------------
// plka_ram
// simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module plka_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/plka_div.sv */
// ---------------------------------------------------------------------------
// plka_div
// shared restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module plka_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  plka_pkg::plka_div_req_t req,
  output plka_pkg::plka_div_rsp_t rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [plka_pkg::STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [plka_pkg::DVD_W-1:0]    dvd_r, dvd_nxt;
  logic [plka_pkg::DVS_W-1:0]    dvs_r, dvs_nxt;
  logic [plka_pkg::DVS_W-1:0]    rem_r, rem_nxt;
  logic [plka_pkg::DVS_W-1:0]    quo_r, quo_nxt;
  logic [plka_pkg::DVS_W:0]      trial;
  logic                          ge;

  assign trial = {rem_r, dvd_r[plka_pkg::DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      dvd_nxt  = req.dvd;
      dvs_nxt  = req.dvs;
      rem_nxt  = req.rem_init;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? plka_pkg::DVS_W'(trial - {1'b0, dvs_r}) : trial[plka_pkg::DVS_W-1:0];
      quo_nxt = {quo_r[plka_pkg::DVS_W-2:0], ge};
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == plka_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

/* rtl/piecewise_linear_keyframe_animator.sv */
// ---------------------------------------------------------------------------
// piecewise_linear_keyframe_animator
// looping piecewise linear keyframe animator with a shared divider
// ---------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready. Duration, start and stop writes load
// the segment tables. A tick request advances the position, wraps it by the
// cycle length, finds the active segment and interpolates each component in
// use, then emits one result per component on out_valid/out_ready with last
// set on the final one.
// A tick sums the segment lengths into the cycle length, wraps the position
// through the shared divider when it overruns that length, searches the
// segments in order and runs one division per component on the shared
// divider (one quotient bit per cycle). in_ready is low for the whole tick.
// After reset the value and length memories are cleared, one entry per cycle,
// with in_ready low; configuration writes are taken throughout. Results sit in
// an output register: a stalled receiver holds the tick in its emit phase
// until the last result is loaded into that register.
// ---------------------------------------------------------------------------
`include "piecewise_linear_keyframe_animator_macros.svh"

module piecewise_linear_keyframe_animator #(
  parameter int MAX_SEGMENTS   = 16,
  parameter int MAX_COMPONENTS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  plka_pkg::plka_in_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output plka_pkg::plka_out_t          out_data,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [plka_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  localparam int SEG_AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int COMP_AW   = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int VAL_DEPTH = MAX_SEGMENTS * MAX_COMPONENTS;
  localparam int VAL_AW    = (VAL_DEPTH > 1) ? $clog2(VAL_DEPTH) : 1;
  localparam int SEGC_W    = $clog2(MAX_SEGMENTS + 1);
  localparam int CLR_W     = $clog2(VAL_DEPTH + 1);
  localparam int CYC_W     = plka_pkg::DUR_W + $clog2(MAX_SEGMENTS);
  localparam int ACC_W     = ((CYC_W > plka_pkg::SUM_W) ? CYC_W : plka_pkg::SUM_W) + 1;

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_SUM_RD   = 4'd2;
  localparam logic [3:0] ST_SUM_ACC  = 4'd3;
  localparam logic [3:0] ST_WRAP     = 4'd4;
  localparam logic [3:0] ST_MOD_GO   = 4'd5;
  localparam logic [3:0] ST_MOD_WAIT = 4'd6;
  localparam logic [3:0] ST_SRCH_RD  = 4'd7;
  localparam logic [3:0] ST_SRCH_CHK = 4'd8;
  localparam logic [3:0] ST_VAL_RD   = 4'd9;
  localparam logic [3:0] ST_VAL_MUL  = 4'd10;
  localparam logic [3:0] ST_DIV_GO   = 4'd11;
  localparam logic [3:0] ST_DIV_WAIT = 4'd12;
  localparam logic [3:0] ST_EMIT     = 4'd13;

  logic [3:0]                        state_r, state_nxt;
  logic [CLR_W-1:0]                  clr_r, clr_nxt;
  logic [plka_pkg::CNT_W-1:0]        segs_cfg_r, comps_cfg_r;
  logic [plka_pkg::POS_W-1:0]        position_r, position_nxt;
  logic [plka_pkg::PER_W-1:0]        period_r, period_nxt;
  logic [SEGC_W-1:0]                 idx_r, idx_nxt;
  logic [ACC_W-1:0]                  cyc_r, cyc_nxt;
  logic [ACC_W-1:0]                  off_r, off_nxt;
  logic [SEG_AW-1:0]                 seg_sel_r, seg_sel_nxt;
  logic [plka_pkg::DUR_W-1:0]        t_r, t_nxt;
  logic [plka_pkg::DUR_W-1:0]        len_r, len_nxt;
  logic [plka_pkg::CNT_W-1:0]        comp_r, comp_nxt;
  logic [plka_pkg::VAL_W-1:0]        a_r, a_nxt;
  logic                              neg_r, neg_nxt;
  logic [plka_pkg::DVD_W-1:0]        prod_r, prod_nxt;
  logic [plka_pkg::VAL_W-1:0]        cur_r [MAX_COMPONENTS];
  logic                              cur_we;
  logic [plka_pkg::VAL_W-1:0]        cur_wdata;
  logic                              out_valid_r, out_valid_nxt;
  plka_pkg::plka_out_t               out_r, out_nxt;

  logic [SEGC_W-1:0]                 nseg;
  logic [plka_pkg::CNT_W-1:0]        ncomp;
  logic                              in_fire;
  logic                              cfg_wr;
  logic                              seg_ok, comp_ok;
  logic [plka_pkg::SUM_W-1:0]        pos_sum;
  logic [plka_pkg::SUM_W-1:0]        pos_m1;
  logic [plka_pkg::VAL_W:0]          diff;
  logic [plka_pkg::VAL_W-1:0]        mag;
  logic [plka_pkg::VAL_W-1:0]        quo_signed;

  logic                              seg_we;
  logic [SEG_AW-1:0]                 seg_waddr, seg_raddr;
  logic [plka_pkg::DUR_W-1:0]        seg_wdata, seg_rdata;
  logic                              start_we, stop_we;
  logic [VAL_AW-1:0]                 val_waddr, val_raddr;
  logic [plka_pkg::VAL_W-1:0]        val_wdata, start_rdata, stop_rdata;

  plka_pkg::plka_div_req_t           div_req;
  plka_pkg::plka_div_rsp_t           div_rsp;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == plka_pkg::REG_COMPS) ? {27'd0, comps_cfg_r}
                                                            : {27'd0, segs_cfg_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      segs_cfg_r  <= '0;
      comps_cfg_r <= plka_pkg::CNT_W'(1);
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == plka_pkg::REG_COMPS) begin
        comps_cfg_r <= cfg_pwdata[plka_pkg::CNT_W-1:0];
      end else begin
        segs_cfg_r <= cfg_pwdata[plka_pkg::CNT_W-1:0];
      end
    end
  end

  assign nseg  = (32'(segs_cfg_r) > MAX_SEGMENTS) ? SEGC_W'(MAX_SEGMENTS)
                                                  : SEGC_W'(segs_cfg_r);
  assign ncomp = (32'(comps_cfg_r) > MAX_COMPONENTS) ? plka_pkg::CNT_W'(MAX_COMPONENTS)
                                                     : comps_cfg_r;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid & in_ready;
  assign seg_ok   = 32'(in_data.segment_index) < MAX_SEGMENTS;
  assign comp_ok  = 32'(in_data.component_index) < MAX_COMPONENTS;

  // memory write ports: clearing sweep or table writes
  always_comb begin
    if (state_r == ST_CLEAR) begin
      seg_we    = 32'(clr_r) < MAX_SEGMENTS;
      seg_waddr = SEG_AW'(clr_r);
      seg_wdata = '0;
      start_we  = 1'b1;
      stop_we   = 1'b1;
      val_waddr = clr_r[VAL_AW-1:0];
      val_wdata = '0;
    end else begin
      seg_we    = in_fire && (in_data.operation == plka_pkg::OP_DUR) && seg_ok;
      seg_waddr = SEG_AW'(in_data.segment_index);
      seg_wdata = in_data.duration_ms;
      start_we  = in_fire && (in_data.operation == plka_pkg::OP_START) && seg_ok && comp_ok;
      stop_we   = in_fire && (in_data.operation == plka_pkg::OP_STOP) && seg_ok && comp_ok;
      val_waddr = VAL_AW'(32'(in_data.segment_index) * MAX_COMPONENTS
                          + 32'(in_data.component_index));
      val_wdata = in_data.endpoint_value;
    end
  end

  assign seg_raddr = SEG_AW'(idx_r);
  assign val_raddr = VAL_AW'(32'(seg_sel_r) * MAX_COMPONENTS + 32'(comp_r));

  plka_ram #(.WIDTH(plka_pkg::DUR_W), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
    .clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(seg_wdata),
    .raddr(seg_raddr), .rdata(seg_rdata)
  );

  plka_ram #(.WIDTH(plka_pkg::VAL_W), .DEPTH(VAL_DEPTH)) u_start_ram (
    .clk(clk), .we(start_we), .waddr(val_waddr), .wdata(val_wdata),
    .raddr(val_raddr), .rdata(start_rdata)
  );

  plka_ram #(.WIDTH(plka_pkg::VAL_W), .DEPTH(VAL_DEPTH)) u_stop_ram (
    .clk(clk), .we(stop_we), .waddr(val_waddr), .wdata(val_wdata),
    .raddr(val_raddr), .rdata(stop_rdata)
  );

  plka_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp)
  );

  assign pos_sum    = plka_pkg::SUM_W'(position_r) + plka_pkg::SUM_W'(period_r);
  assign pos_m1     = pos_sum - plka_pkg::SUM_W'(1);
  assign diff       = {stop_rdata[plka_pkg::VAL_W-1], stop_rdata}
                    - {start_rdata[plka_pkg::VAL_W-1], start_rdata};
  assign mag        = diff[plka_pkg::VAL_W] ? plka_pkg::VAL_W'(-diff)
                                            : diff[plka_pkg::VAL_W-1:0];
  assign quo_signed = neg_r ? (-div_rsp.quo) : div_rsp.quo;

  // shared divider requests: wrap modulo, then one interpolation per component
  always_comb begin
    div_req = '0;
    if (state_r == ST_MOD_GO) begin
      div_req.start    = 1'b1;
      div_req.steps    = plka_pkg::STEP_W'(plka_pkg::MOD_STEPS);
      div_req.dvd      = {pos_m1, (plka_pkg::DVD_W - plka_pkg::SUM_W)'(0)};
      div_req.rem_init = '0;
      div_req.dvs      = plka_pkg::DVS_W'(cyc_r);
    end else if (state_r == ST_DIV_GO) begin
      div_req.start    = 1'b1;
      div_req.steps    = plka_pkg::STEP_W'(plka_pkg::DIV_STEPS);
      div_req.dvd      = {prod_r[plka_pkg::DVS_W-1:0],
                          (plka_pkg::DVD_W - plka_pkg::DVS_W)'(0)};
      div_req.rem_init = plka_pkg::DVS_W'(prod_r[plka_pkg::DVD_W-1:plka_pkg::DVS_W]);
      div_req.dvs      = plka_pkg::DVS_W'(len_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    position_nxt  = position_r;
    period_nxt    = period_r;
    idx_nxt       = idx_r;
    cyc_nxt       = cyc_r;
    off_nxt       = off_r;
    seg_sel_nxt   = seg_sel_r;
    t_nxt         = t_r;
    len_nxt       = len_r;
    comp_nxt      = comp_r;
    a_nxt         = a_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    cur_we        = 1'b0;
    cur_wdata     = a_r + quo_signed;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_nxt       = out_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == VAL_DEPTH - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire && (in_data.operation == plka_pkg::OP_TICK)) begin
          period_nxt = in_data.period_ms;
          idx_nxt    = '0;
          cyc_nxt    = '0;
          comp_nxt   = '0;
          state_nxt  = (nseg == '0) ? ST_EMIT : ST_SUM_RD;
        end
      end
      ST_SUM_RD: begin
        state_nxt = ST_SUM_ACC;
      end
      ST_SUM_ACC: begin
        cyc_nxt = cyc_r + ACC_W'(seg_rdata);
        idx_nxt = idx_r + 1'b1;
        state_nxt = (SEGC_W'(idx_r + 1'b1) == nseg) ? ST_WRAP : ST_SUM_RD;
      end
      ST_WRAP: begin
        idx_nxt = '0;
        off_nxt = '0;
        if (cyc_r == '0) begin
          state_nxt = ST_EMIT;
        end else if (ACC_W'(pos_sum) > cyc_r) begin
          state_nxt = ST_MOD_GO;
        end else begin
          position_nxt = plka_pkg::POS_W'(pos_sum);
          state_nxt    = ST_SRCH_RD;
        end
      end
      ST_MOD_GO: begin
        state_nxt = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: begin
        if (div_rsp.done) begin
          position_nxt = plka_pkg::POS_W'(div_rsp.rem + 32'd1);
          state_nxt    = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        state_nxt = ST_SRCH_CHK;
      end
      ST_SRCH_CHK: begin
        if (ACC_W'(position_r) < off_r + ACC_W'(seg_rdata)) begin
          seg_sel_nxt = SEG_AW'(idx_r);
          t_nxt       = plka_pkg::DUR_W'(ACC_W'(position_r) - off_r);
          len_nxt     = seg_rdata;
          state_nxt   = (ncomp == '0) ? ST_EMIT : ST_VAL_RD;
        end else begin
          off_nxt   = off_r + ACC_W'(seg_rdata);
          idx_nxt   = idx_r + 1'b1;
          // no segment holds the position: values stay
          state_nxt = (SEGC_W'(idx_r + 1'b1) == nseg) ? ST_EMIT : ST_SRCH_RD;
        end
      end
      ST_VAL_RD: begin
        state_nxt = ST_VAL_MUL;
      end
      ST_VAL_MUL: begin
        a_nxt     = start_rdata;
        neg_nxt   = diff[plka_pkg::VAL_W];
        prod_nxt  = {{(plka_pkg::DVD_W - plka_pkg::DUR_W){1'b0}}, t_r}
                  * {{(plka_pkg::DVD_W - plka_pkg::VAL_W){1'b0}}, mag};
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          cur_we   = 1'b1;
          comp_nxt = comp_r + 1'b1;
          if (comp_r + 1'b1 == ncomp) begin
            comp_nxt  = '0;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_VAL_RD;
          end
        end
      end
      ST_EMIT: begin
        if (ncomp == '0) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_nxt.out_component = comp_r[3:0];
          out_nxt.out_value     = cur_r[comp_r[COMP_AW-1:0]];
          out_nxt.last          = (comp_r + 1'b1 == ncomp);
          comp_nxt              = comp_r + 1'b1;
          if (comp_r + 1'b1 == ncomp) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      position_r  <= '0;
      comp_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_COMPONENTS; i++) begin
        cur_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      position_r  <= position_nxt;
      comp_r      <= comp_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cur_we) begin
        cur_r[comp_r[COMP_AW-1:0]] <= cur_wdata;
      end
    end
    period_r  <= period_nxt;
    cyc_r     <= cyc_nxt;
    off_r     <= off_nxt;
    seg_sel_r <= seg_sel_nxt;
    t_r       <= t_nxt;
    len_r     <= len_nxt;
    a_r       <= a_nxt;
    neg_r     <= neg_nxt;
    prod_r    <= prod_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PLKA_ASSERT_IMP(a_clear_quiet, clk, rst_n, state_r == ST_CLEAR, !out_valid_r && !in_ready)
  `PLKA_ASSERT_IMP(a_div_start_free, clk, rst_n, div_req.start, !div_rsp.busy)
  `PLKA_ASSERT_IMP(a_div_done_wait, clk, rst_n, div_rsp.done,
                   state_r == ST_MOD_WAIT || state_r == ST_DIV_WAIT)
  `PLKA_ASSERT_NXT(a_wrap_in_cycle, clk, rst_n,
                   state_r == ST_MOD_WAIT && div_rsp.done, ACC_W'(position_r) <= cyc_r)

endmodule
